// File: src/rsgr_pkg.sv
// Shared widths, register codes, limits and pipeline bundles for the
// slant-to-ground range converter. No dependencies.
package rsgr_pkg;

    localparam int RANGE_W    = 26;
    localparam int TALT_W     = 23;
    localparam int HGT_W      = 20;
    localparam int RAD_W      = 30;
    localparam int GND_W      = 26;
    localparam int ALT_W      = 27;
    localparam int SINE_W     = 32;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 30;

    localparam int SINE_FRACTION_BITS_DEF = 30;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_EARTH_RADIUS = 1'b0,
        REG_RADAR_HEIGHT = 1'b1
    } t_cfg_reg;

    localparam logic [RAD_W-1:0]  EARTH_RADIUS_RST = 30'd633543900;
    localparam logic [GND_W-1:0]  GROUND_MAX       = 26'd50000000;
    localparam logic signed [27:0] ALT_MIN         = -28'sd50050000;
    localparam logic signed [27:0] ALT_MAX         = 28'sd50500000;

    // Per-beat control carried alongside the dividers
    typedef struct packed {
        logic                    ok;
        logic                    neg;
        logic [RANGE_W-1:0]      rho;
        logic signed [HGT_W-1:0] h;
    } t_head;

    // Per-beat results carried alongside the square root
    typedef struct packed {
        logic               ok;
        logic [RANGE_W-1:0] rho;
        logic [ALT_W-1:0]   alt;
        logic [SINE_W-1:0]  sine;
    } t_tail;

endpackage

// File: src/radar_slant_to_ground_range.sv
// Slant range to ground range on a locally spherical earth, fully pipelined.
// Depends on rsgr_pkg (widths, register codes, limits, pipeline bundles).
//
// Usage:
//   Input beat: present i_slant_range_cm, i_has_altitude and
//   i_target_altitude_cm with start high; it is taken at any edge where busy
//   is low. busy is always low: a new beat may enter on every clock.
//   Result beat: o_done is high for exactly one cycle with ground range,
//   adjusted altitude, elevation sine and its valid flag. Results come out in
//   input order; the receiver cannot stall, so none are held back.
//   Throughput: one beat per cycle.
//   The pipeline depth is set by the two restoring dividers (one quotient bit per
//   stage, run side by side) and the 26-stage square root pipeline.
//   Configuration: i_cfg_we writes earth radius (index 0) or radar height
//   (index 1) from i_cfg_data at once; change it only with no beat in flight.
//   Reset (synchronous, active low) empties the pipeline and restores the
//   radius to 633543900 cm and the height to zero.
module radar_slant_to_ground_range #(
    parameter int SINE_FRACTION_BITS = rsgr_pkg::SINE_FRACTION_BITS_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   start,
    output logic                                   busy,
    input  logic [rsgr_pkg::RANGE_W-1:0]           i_slant_range_cm,
    input  logic                                   i_has_altitude,
    input  logic signed [rsgr_pkg::TALT_W-1:0]     i_target_altitude_cm,
    input  logic                                   i_cfg_we,
    input  logic [rsgr_pkg::CFG_IDX_W-1:0]         i_cfg_idx,
    input  logic [rsgr_pkg::CFG_DATA_W-1:0]        i_cfg_data,
    output logic                                   o_done,
    output logic [rsgr_pkg::GND_W-1:0]             o_ground_range_cm,
    output logic signed [rsgr_pkg::ALT_W-1:0]      o_adjusted_altitude_cm,
    output logic signed [rsgr_pkg::SINE_W-1:0]     o_elevation_sine,
    output logic                                   o_elevation_valid
);

    localparam int F    = SINE_FRACTION_BITS;
    localparam int AW   = rsgr_pkg::RANGE_W;
    localparam int NDIV = (F > AW) ? F : AW;
    localparam int QW   = F + 1;
    localparam int SW   = (QW > 32) ? QW : 32;
    localparam int LAT  = 8 + NDIV + AW;
    localparam logic [SW-1:0] SINE_LIM = SW'(64'h8000_0000);

    // Configuration registers
    logic [rsgr_pkg::RAD_W-1:0]        r_radius;
    logic signed [rsgr_pkg::HGT_W-1:0] r_height;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= rsgr_pkg::EARTH_RADIUS_RST;
            r_height <= '0;
        end else if (i_cfg_we) begin
            unique case (rsgr_pkg::t_cfg_reg'(i_cfg_idx))
                rsgr_pkg::REG_EARTH_RADIUS: r_radius <= i_cfg_data;
                rsgr_pkg::REG_RADAR_HEIGHT: r_height <= i_cfg_data[rsgr_pkg::HGT_W-1:0];
            endcase
        end
    end

    assign busy = 1'b0;

    // Stage A: pick target height, form H-h and R+h
    logic                 r_a_vld;
    logic [AW-1:0]        r_a_rho;
    logic signed [19:0]   r_a_h;
    logic signed [22:0]   r_a_hgt;
    logic signed [23:0]   r_a_dhh;
    logic [29:0]          r_a_r;
    logic [31:0]          r_a_rh;
    logic signed [22:0]   n_a_hgt;
    logic [23:0]          n_a_dhh;
    logic [31:0]          n_a_rh;

    always_comb begin
        n_a_hgt = i_has_altitude ? i_target_altitude_cm : {{3{r_height[19]}}, r_height};
        n_a_dhh = {n_a_hgt[22], n_a_hgt} - {{4{r_height[19]}}, r_height};
        n_a_rh  = {2'b00, r_radius} + {{12{r_height[19]}}, r_height};
    end

    always_ff @(posedge i_clk) begin
        r_a_rho <= i_slant_range_cm;
        r_a_h   <= r_height;
        r_a_hgt <= n_a_hgt;
        r_a_dhh <= n_a_dhh;
        r_a_r   <= r_radius;
        r_a_rh  <= n_a_rh;
    end

    // Stage B: the products
    logic                 r_b_vld;
    logic                 r_b_ok;
    logic [AW-1:0]        r_b_rho;
    logic signed [19:0]   r_b_h;
    logic signed [54:0]   r_b_p1;
    logic signed [45:0]   r_b_p2;
    logic signed [39:0]   r_b_p3;
    logic [51:0]          r_b_p4;
    logic [56:0]          r_b_pd;
    logic [31:0]          r_b_d2;

    always_ff @(posedge i_clk) begin
        r_b_ok  <= (r_a_rho != '0) && !r_a_rh[31] && (r_a_rh != '0);
        r_b_rho <= r_a_rho;
        r_b_h   <= r_a_h;
        r_b_p1  <= $signed({1'b0, r_a_r}) * r_a_dhh;
        r_b_p2  <= r_a_hgt * r_a_hgt;
        r_b_p3  <= r_a_h * r_a_h;
        r_b_p4  <= r_a_rho * r_a_rho;
        r_b_pd  <= r_a_rho * r_a_rh[30:0];
        r_b_d2  <= {r_a_rh[30:0], 1'b0};
    end

    // Stage C: numerator sum
    logic                 r_c_vld;
    logic                 r_c_ok;
    logic [AW-1:0]        r_c_rho;
    logic signed [19:0]   r_c_h;
    logic [57:0]          r_c_num;
    logic [57:0]          r_c_den;
    logic [31:0]          r_c_d2;

    always_ff @(posedge i_clk) begin
        r_c_ok  <= r_b_ok;
        r_c_rho <= r_b_rho;
        r_c_h   <= r_b_h;
        r_c_num <= {{2{r_b_p1[54]}}, r_b_p1, 1'b0} + {{12{r_b_p2[45]}}, r_b_p2}
                 - {{18{r_b_p3[39]}}, r_b_p3} - {6'b0, r_b_p4};
        r_c_den <= {r_b_pd, 1'b0};
        r_c_d2  <= r_b_d2;
    end

    // Stage D: magnitude and sign
    logic                 r_d_vld;
    rsgr_pkg::t_head      r_d_hd;
    logic [56:0]          r_d_mag;
    logic [57:0]          r_d_den;
    logic [31:0]          r_d_d2;

    always_ff @(posedge i_clk) begin
        r_d_hd.ok  <= r_c_ok;
        r_d_hd.neg <= r_c_num[57];
        r_d_hd.rho <= r_c_rho;
        r_d_hd.h   <= r_c_h;
        r_d_mag    <= r_c_num[57] ? (~r_c_num[56:0] + 57'd1) : r_c_num[56:0];
        r_d_den    <= r_c_den;
        r_d_d2     <= r_c_d2;
    end

    // Divider pipeline: sine quotient and altitude offset, one bit a stage
    logic                 r_dv_vld [0:NDIV];
    rsgr_pkg::t_head      r_dv_hd  [0:NDIV];
    logic [57:0]          r_dv_den [0:NDIV];
    logic [QW-1:0]        r_dv_sq  [0:NDIV];
    logic [57:0]          r_dv_sr  [0:NDIV];
    logic [58:0]          r_dv_an  [0:NDIV];
    logic [32:0]          r_dv_ae  [0:NDIV];
    logic [AW-1:0]        r_dv_aq  [0:NDIV];
    logic                 n_e_ge;

    // Stage E: range check and first quotient bit
    always_comb begin
        n_e_ge = {1'b0, r_d_mag} >= r_d_den;
    end

    always_ff @(posedge i_clk) begin
        r_dv_hd[0].ok  <= r_d_hd.ok && ({1'b0, r_d_mag} <= r_d_den);
        r_dv_hd[0].neg <= r_d_hd.neg;
        r_dv_hd[0].rho <= r_d_hd.rho;
        r_dv_hd[0].h   <= r_d_hd.h;
        r_dv_den[0]    <= r_d_den;
        r_dv_sq[0]     <= QW'(n_e_ge);
        r_dv_sr[0]     <= {1'b0, r_d_mag} - (n_e_ge ? r_d_den : 58'd0);
        r_dv_an[0]     <= {1'b0, r_d_mag, 1'b0} + {27'b0, r_d_d2};
        r_dv_ae[0]     <= {r_d_d2, 1'b0};
        r_dv_aq[0]     <= '0;
    end

    for (genvar k = 0; k < NDIV; k++) begin : g_div
        localparam int SH = (k < AW) ? (AW - 1 - k) : 0;
        logic [58:0]   n_t;
        logic [57:0]   n_sr;
        logic [QW-1:0] n_sq;
        logic [58:0]   n_s;
        logic [58:0]   n_an;
        logic [AW-1:0] n_aq;

        always_comb begin
            n_t  = {r_dv_sr[k], 1'b0};
            n_sr = r_dv_sr[k];
            n_sq = r_dv_sq[k];
            if (k < F) begin
                if (n_t >= {1'b0, r_dv_den[k]}) begin
                    n_sr = 58'(n_t - {1'b0, r_dv_den[k]});
                    n_sq = {r_dv_sq[k][QW-2:0], 1'b1};
                end else begin
                    n_sr = n_t[57:0];
                    n_sq = {r_dv_sq[k][QW-2:0], 1'b0};
                end
            end
            n_s  = 59'(r_dv_ae[k]) << SH;
            n_an = r_dv_an[k];
            n_aq = r_dv_aq[k];
            if (k < AW) begin
                if (r_dv_an[k] >= n_s) begin
                    n_an     = r_dv_an[k] - n_s;
                    n_aq[SH] = 1'b1;
                end
            end
        end

        always_ff @(posedge i_clk) begin
            r_dv_hd[k+1]  <= r_dv_hd[k];
            r_dv_den[k+1] <= r_dv_den[k];
            r_dv_sq[k+1]  <= n_sq;
            r_dv_sr[k+1]  <= n_sr;
            r_dv_an[k+1]  <= n_an;
            r_dv_ae[k+1]  <= r_dv_ae[k];
            r_dv_aq[k+1]  <= n_aq;
        end
    end

    // Stage G: round and saturate sine, square offset and range, sum altitude
    logic                 r_g_vld;
    logic                 r_g_ok;
    logic [AW-1:0]        r_g_rho;
    logic signed [19:0]   r_g_h;
    logic [31:0]          r_g_sine;
    logic [51:0]          r_g_aa;
    logic [51:0]          r_g_rr;
    logic signed [27:0]   r_g_alt;
    logic [QW-1:0]        n_g_smag;
    logic [SW-1:0]        n_g_sm;
    logic [31:0]          n_g_sine;
    logic [27:0]          n_g_off;

    always_comb begin
        n_g_smag = r_dv_sq[NDIV]
                 + QW'({r_dv_sr[NDIV], 1'b0} >= {1'b0, r_dv_den[NDIV]});
        n_g_sm   = SW'(n_g_smag);
        if (!r_dv_hd[NDIV].ok) begin
            n_g_sine = '0;
        end else if (r_dv_hd[NDIV].neg) begin
            n_g_sine = (n_g_sm >= SINE_LIM) ? 32'h8000_0000 : 32'(SW'(0) - n_g_sm);
        end else begin
            n_g_sine = (n_g_sm >= SINE_LIM) ? 32'h7FFF_FFFF : n_g_sm[31:0];
        end
        n_g_off = r_dv_hd[NDIV].neg ? (28'd0 - {2'b0, r_dv_aq[NDIV]})
                                    : {2'b0, r_dv_aq[NDIV]};
    end

    always_ff @(posedge i_clk) begin
        r_g_ok   <= r_dv_hd[NDIV].ok;
        r_g_rho  <= r_dv_hd[NDIV].rho;
        r_g_h    <= r_dv_hd[NDIV].h;
        r_g_sine <= n_g_sine;
        r_g_aa   <= r_dv_aq[NDIV] * r_dv_aq[NDIV];
        r_g_rr   <= r_dv_hd[NDIV].rho * r_dv_hd[NDIV].rho;
        r_g_alt  <= {{8{r_dv_hd[NDIV].h[19]}}, r_dv_hd[NDIV].h} + n_g_off;
    end

    // Square root pipeline over rho^2 - a^2
    logic                 r_sq_vld  [0:AW];
    rsgr_pkg::t_tail      r_sq_tl   [0:AW];
    logic [51:0]          r_sq_rem  [0:AW];
    logic [AW-1:0]        r_sq_root [0:AW];
    logic [26:0]          n_h_alt;

    // Stage H: clamp altitude (radar height if invalid), start the root
    always_comb begin
        if (!r_g_ok) begin
            n_h_alt = {{7{r_g_h[19]}}, r_g_h};
        end else if (r_g_alt < rsgr_pkg::ALT_MIN) begin
            n_h_alt = rsgr_pkg::ALT_MIN[26:0];
        end else if (r_g_alt > rsgr_pkg::ALT_MAX) begin
            n_h_alt = rsgr_pkg::ALT_MAX[26:0];
        end else begin
            n_h_alt = r_g_alt[26:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_sq_tl[0].ok   <= r_g_ok;
        r_sq_tl[0].rho  <= r_g_rho;
        r_sq_tl[0].alt  <= n_h_alt;
        r_sq_tl[0].sine <= r_g_sine;
        r_sq_rem[0]     <= r_g_rr - r_g_aa;
        r_sq_root[0]    <= '0;
    end

    for (genvar j = 0; j < AW; j++) begin : g_sqrt
        localparam int SH = AW - 1 - j;
        logic [52:0]   n_t;
        logic [51:0]   n_rem;
        logic [AW-1:0] n_root;

        always_comb begin
            n_t    = (53'(r_sq_root[j]) << (SH + 1)) + (53'd1 << (2 * SH));
            n_rem  = r_sq_rem[j];
            n_root = r_sq_root[j];
            if ({1'b0, r_sq_rem[j]} >= n_t) begin
                n_rem      = 52'({1'b0, r_sq_rem[j]} - n_t);
                n_root[SH] = 1'b1;
            end
        end

        always_ff @(posedge i_clk) begin
            r_sq_tl[j+1]   <= r_sq_tl[j];
            r_sq_rem[j+1]  <= n_rem;
            r_sq_root[j+1] <= n_root;
        end
    end

    // Output stage: round root, select and clamp ground range
    logic                 r_o_vld;
    logic [25:0]          r_o_gnd;
    logic [26:0]          r_o_alt;
    logic [31:0]          r_o_sine;
    logic                 r_o_ok;
    logic [26:0]          n_o_root;
    logic [26:0]          n_o_gnd;

    always_comb begin
        n_o_root = {1'b0, r_sq_root[AW]}
                 + 27'(r_sq_rem[AW] > {26'b0, r_sq_root[AW]});
        n_o_gnd  = r_sq_tl[AW].ok ? n_o_root : {1'b0, r_sq_tl[AW].rho};
    end

    always_ff @(posedge i_clk) begin
        r_o_gnd  <= (n_o_gnd > {1'b0, rsgr_pkg::GROUND_MAX}) ? rsgr_pkg::GROUND_MAX
                                                            : n_o_gnd[25:0];
        r_o_alt  <= r_sq_tl[AW].alt;
        r_o_sine <= r_sq_tl[AW].sine;
        r_o_ok   <= r_sq_tl[AW].ok;
    end

    // Valid bits: advance every cycle, clear on reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
            r_d_vld <= 1'b0;
            r_g_vld <= 1'b0;
            r_o_vld <= 1'b0;
        end else begin
            r_a_vld <= start && !busy;
            r_b_vld <= r_a_vld;
            r_c_vld <= r_b_vld;
            r_d_vld <= r_c_vld;
            r_g_vld <= r_dv_vld[NDIV];
            r_o_vld <= r_sq_vld[AW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv_vld[0] <= 1'b0;
            r_sq_vld[0] <= 1'b0;
        end else begin
            r_dv_vld[0] <= r_d_vld;
            r_sq_vld[0] <= r_g_vld;
        end
    end

    for (genvar v = 0; v < NDIV; v++) begin : g_dv_vld
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_vld[v+1] <= 1'b0;
            end else begin
                r_dv_vld[v+1] <= r_dv_vld[v];
            end
        end
    end

    for (genvar u = 0; u < AW; u++) begin : g_sq_vld
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sq_vld[u+1] <= 1'b0;
            end else begin
                r_sq_vld[u+1] <= r_sq_vld[u];
            end
        end
    end

    assign o_done                 = r_o_vld;
    assign o_ground_range_cm      = r_o_gnd;
    assign o_adjusted_altitude_cm = r_o_alt;
    assign o_elevation_sine       = r_o_sine;
    assign o_elevation_valid      = r_o_ok;

    // Every accepted beat leaves after the fixed pipeline depth
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##LAT o_done)
        else $error("result beat missing at pipeline exit");

    // An invalid elevation carries a zero sine
    a_inv_sine: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_elevation_valid) |-> (o_elevation_sine == '0))
        else $error("invalid elevation with nonzero sine");

    // Ground range stays inside its saturation limit
    a_gnd_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_ground_range_cm <= rsgr_pkg::GROUND_MAX))
        else $error("ground range above limit");

    // No stage G beat without an item entering the divider pipeline earlier
    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_g_vld) |-> $past(r_dv_vld[0], NDIV + 1))
        else $error("beat appeared in the pipeline from nowhere");

endmodule
